### design/fit_policy_block_allocator_macros.svh
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FPBA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FPBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

### design/fpba_pkg.sv
`default_nettype none
package fpba_pkg;

   localparam int NUM_BLOCKS = 8;
   localparam int SIZE_BITS = 16;
   localparam int IDX_BITS = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int LIMIT_BITS = 4;
   localparam int MODE_BITS = 2;
   localparam int CSR_IDX_BITS = 1;
   localparam int CSR_DATA_BITS = 4;
   localparam logic [LIMIT_BITS-1:0] BLOCKS_IN_USE_RESET = LIMIT_BITS'(8);

   typedef logic [SIZE_BITS-1:0] size_type;
   typedef logic [IDX_BITS-1:0] idx_type;
   typedef logic [LIMIT_BITS-1:0] limit_type;
   typedef logic [MODE_BITS-1:0] mode_type;

   localparam mode_type FIT_FIRST = 2'd0;
   localparam mode_type FIT_BEST = 2'd1;
   localparam mode_type FIT_WORST = 2'd2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_FIT_MODE = 1'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BLOCKS_IN_USE = 1'd1;

   typedef struct packed {
      logic      valid;
      logic      found;
      idx_type   pick;
      size_type  pick_size;
      size_type  req;
      mode_type  mode;
      limit_type limit;
   } token_type;

   typedef struct packed {
      logic     en;
      size_type data;
   } cell_wr_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_DONE   = 3'b100
   } state_type;

endpackage
`default_nettype wire

### design/fpba_ifs.sv
`default_nettype none
interface fpba_req_if;
   import fpba_pkg::*;
   logic        valid;
   logic        ready;
   logic        command;
   logic [2:0]  load_index;
   logic [15:0] load_size;
   logic [15:0] request_size;
   modport source (output valid, command, load_index, load_size, request_size, input ready);
   modport sink (input valid, command, load_index, load_size, request_size, output ready);
endinterface

interface fpba_rsp_if;
   logic        valid;
   logic        ready;
   logic        granted;
   logic [2:0]  block_index;
   logic [15:0] remaining_size;
   modport source (output valid, granted, block_index, remaining_size, input ready);
   modport sink (input valid, granted, block_index, remaining_size, output ready);
endinterface

interface fpba_csr_if;
   import fpba_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [CSR_IDX_BITS-1:0]  index;
   logic [CSR_DATA_BITS-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### design/fpba_cell.sv
`default_nettype none
module fpba_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire fpba_pkg::idx_type    cell_index,
   input  wire fpba_pkg::cell_wr_type wr,
   input  wire fpba_pkg::token_type  tok_in,
   output fpba_pkg::token_type       tok_out
);
   import fpba_pkg::*;

   size_type  size_ff, size_in;
   token_type tok_ff, tok_in_next;
   logic      considered, fits, better, take;

   always_comb begin
      considered = limit_type'(cell_index) < tok_in.limit;
      fits = size_ff >= tok_in.req;
      case (tok_in.mode)
         FIT_BEST: better = size_ff < tok_in.pick_size;
         FIT_WORST: better = size_ff > tok_in.pick_size;
         default: better = 1'b0;
      endcase
      take = considered && fits && (!tok_in.found || better);
      tok_in_next = tok_in;
      if (take) begin
         tok_in_next.found = 1'b1;
         tok_in_next.pick = cell_index;
         tok_in_next.pick_size = size_ff;
      end
      size_in = wr.en ? wr.data : size_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= '0;
         tok_ff <= '0;
      end else begin
         size_ff <= size_in;
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out = tok_ff;
endmodule
`default_nettype wire

### design/fit_policy_block_allocator.sv
// Loads write one block size and produce no response.
// An allocation token crosses one block cell per cycle; the result at the end
// of the chain is registered, then loaded into the response register.
// One allocation is in flight at a time: the next item is taken once the result
// has been committed, which waits while the response register is full.
// Synchronous reset clears all block sizes, sets fit_mode 0 and blocks_in_use 8.
`default_nettype none
`include "fit_policy_block_allocator_macros.svh"
module fit_policy_block_allocator (
   input  wire logic clock,
   input  wire logic reset,
   fpba_req_if.sink  req_ch,
   fpba_rsp_if.source rsp_ch,
   fpba_csr_if.sink  csr_ch
);
   import fpba_pkg::*;

   state_type   state_ff, state_in;
   mode_type    mode_ff, mode_in;
   limit_type   limit_ff, limit_in;
   token_type   fin_ff, fin_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_granted_ff, rsp_granted_in;
   idx_type     rsp_index_ff, rsp_index_in;
   size_type    rsp_size_ff, rsp_size_in;
   token_type   tok [NUM_BLOCKS+1];
   cell_wr_type wr [NUM_BLOCKS];
   logic        req_acc, commit;
   size_type    left_size;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign req_acc = req_ch.valid && req_ch.ready;
   assign commit = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign left_size = fin_ff.pick_size - fin_ff.req;

   always_comb begin
      tok[0].valid = req_acc && (req_ch.command == CMD_ALLOC);
      tok[0].found = 1'b0;
      tok[0].pick = '0;
      tok[0].pick_size = '0;
      tok[0].req = size_type'(req_ch.request_size);
      tok[0].mode = mode_ff;
      tok[0].limit = limit_ff;
   end

   for (genvar i = 0; i < NUM_BLOCKS; i++) begin : g_cell
      always_comb begin
         wr[i].en = 1'b0;
         wr[i].data = left_size;
         if (commit && fin_ff.found && (fin_ff.pick == IDX_BITS'(i))) begin
            wr[i].en = 1'b1;
         end else if (req_acc && (req_ch.command == CMD_LOAD)
                      && (32'(req_ch.load_index) == i)) begin
            wr[i].en = 1'b1;
            wr[i].data = size_type'(req_ch.load_size);
         end
      end

      fpba_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_BITS'(i)),
         .wr         (wr[i]),
         .tok_in     (tok[i]),
         .tok_out    (tok[i+1])
      );
   end

   always_comb begin
      state_in = state_ff;
      fin_in = fin_ff;
      case (state_ff)
         ST_IDLE: begin
            if (tok[0].valid) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tok[NUM_BLOCKS].valid) begin
               fin_in = tok[NUM_BLOCKS];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (commit) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = commit || (rsp_valid_ff && !rsp_ch.ready);
      rsp_granted_in = rsp_granted_ff;
      rsp_index_in = rsp_index_ff;
      rsp_size_in = rsp_size_ff;
      if (commit) begin
         rsp_granted_in = fin_ff.found;
         rsp_index_in = fin_ff.found ? fin_ff.pick : '0;
         rsp_size_in = fin_ff.found ? left_size : '0;
      end

      mode_in = mode_ff;
      limit_in = limit_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_FIT_MODE: mode_in = mode_type'(csr_ch.data);
            CSR_BLOCKS_IN_USE: limit_in = limit_type'(csr_ch.data);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= FIT_FIRST;
         limit_ff <= BLOCKS_IN_USE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         limit_ff <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_index_ff <= rsp_index_in;
      rsp_size_ff <= rsp_size_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.granted = rsp_granted_ff;
   assign rsp_ch.block_index = 3'(rsp_index_ff);
   assign rsp_ch.remaining_size = 16'(rsp_size_ff);

   `FPBA_ASSERT_NEXT(a_alloc_starts_search, clock, reset, tok[0].valid, state_ff == ST_SEARCH)
   `FPBA_ASSERT_NOW(a_token_exits_in_search, clock, reset, tok[NUM_BLOCKS].valid, state_ff == ST_SEARCH)
   `FPBA_ASSERT_NOW(a_refusal_is_zero, clock, reset, rsp_valid_ff && !rsp_granted_ff, (rsp_index_ff == '0) && (rsp_size_ff == '0))
   `FPBA_ASSERT_NEXT(a_commit_fills_rsp, clock, reset, commit, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule
`default_nettype wire
